>>> design/sst_pkg.sv
`timescale 1ns / 1ps

package sst_pkg;

    localparam int DEPTH = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PTR_W = ADDR_W + 1;

    localparam int KEY_W = 20;
    localparam int VALUE_W = 20;
    localparam int FLAGS_W = 8;
    localparam int ACTION_W = 3;
    localparam int INDEX_W = 6;
    localparam int STATUS_W = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 20;

    // entries 0..2 are set up by reset and never rewritten
    localparam int INIT_ENTRIES = 3;
    localparam int OPEN_ENTRIES = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_OPEN   = 3'd0,
        ACT_LOCK   = 3'd1,
        ACT_CLOSE  = 3'd2,
        ACT_FIND   = 3'd3,
        ACT_ADD    = 3'd4,
        ACT_QUERY  = 3'd5
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_LOCKED = 2'd2,
        ST_OUTER  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_NORMAL = 2'd0,
        KIND_BASE   = 2'd1,
        KIND_LOCK   = 2'd2
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TYPE_MASK = 2'd0,
        CFG_INH_KEY   = 2'd1,
        CFG_NS_FLAGS  = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        WR_BASE,
        WR_NS0,
        WR_NS1,
        WR_LOCK,
        WR_ADD
    } wr_sel_t;

    localparam logic [FLAGS_W-1:0] RST_TYPE_MASK = 8'd255;
    localparam logic [KEY_W-1:0] RST_INH_KEY = 20'd1;
    localparam logic [FLAGS_W-1:0] RST_NS_FLAGS = 8'd3;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [FLAGS_W-1:0] flags;
        kind_t              kind;
    } entry_t;

    typedef struct packed {
        logic    load;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    set_status;
        status_t status_code;
        logic    close_start;
        logic    find_start;
        logic    rd_en;
        logic    step;
        logic    find_hit;
        logic    close_cmp;
        logic    close_done;
        logic    publish;
    } dp_cmd_t;

    typedef struct packed {
        action_t action;
        logic    open_full;
        logic    push_full;
        logic    top_lock;
        logic    base_zero;
        logic    find_empty;
        logic    at_floor;
        logic    hit;
        logic    is_base;
    } dp_stat_t;

endpackage

>>> design/sst_if.sv
`timescale 1ns / 1ps

interface sst_req_if;
    logic                              valid;
    logic                              ready;
    logic [sst_pkg::ACTION_W-1:0]      action;
    logic [sst_pkg::KEY_W-1:0]         key;
    logic [sst_pkg::VALUE_W-1:0]       value;
    logic [sst_pkg::FLAGS_W-1:0]       flags;

    modport source (output valid, action, key, value, flags, input ready);
    modport sink (input valid, action, key, value, flags, output ready);
endinterface

interface sst_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [sst_pkg::INDEX_W-1:0]       index;
    logic                              found;
    logic                              locked;
    logic [sst_pkg::STATUS_W-1:0]      status;

    modport source (output valid, index, found, locked, status, input ready);
    modport sink (input valid, index, found, locked, status, output ready);
endinterface

>>> design/sst_ctrl.sv
`timescale 1ns / 1ps

module sst_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  sst_pkg::dp_stat_t  stat,
    output sst_pkg::dp_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_OPEN_BASE,
        S_OPEN_NS0,
        S_OPEN_NS1,
        S_FIND_RD,
        S_FIND_CMP,
        S_CLOSE_RD,
        S_CLOSE_CMP,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   slot_free;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        rsp_valid_next = rsp_valid_reg;
        cmd = '0;
        cmd.wr_sel = sst_pkg::WR_BASE;
        cmd.status_code = sst_pkg::ST_OK;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                case (stat.action)
                    sst_pkg::ACT_OPEN:
                    begin
                        if (stat.open_full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status_code = sst_pkg::ST_FULL;
                        end
                        else
                        begin
                            state_next = S_OPEN_BASE;
                        end
                    end
                    sst_pkg::ACT_LOCK:
                    begin
                        if (stat.push_full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status_code = sst_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en = 1'b1;
                            cmd.wr_sel = sst_pkg::WR_LOCK;
                        end
                    end
                    sst_pkg::ACT_CLOSE:
                    begin
                        if (stat.base_zero)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status_code = sst_pkg::ST_OUTER;
                        end
                        else
                        begin
                            cmd.close_start = 1'b1;
                            state_next = S_CLOSE_RD;
                        end
                    end
                    sst_pkg::ACT_FIND:
                    begin
                        cmd.find_start = 1'b1;
                        if (!stat.find_empty)
                        begin
                            state_next = S_FIND_RD;
                        end
                    end
                    sst_pkg::ACT_ADD:
                    begin
                        // lock check comes before the fullness check
                        if (stat.top_lock)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status_code = sst_pkg::ST_LOCKED;
                        end
                        else if (stat.push_full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status_code = sst_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en = 1'b1;
                            cmd.wr_sel = sst_pkg::WR_ADD;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_OPEN_BASE:
            begin
                cmd.wr_en = 1'b1;
                cmd.wr_sel = sst_pkg::WR_BASE;
                state_next = S_OPEN_NS0;
            end
            S_OPEN_NS0:
            begin
                cmd.wr_en = 1'b1;
                cmd.wr_sel = sst_pkg::WR_NS0;
                state_next = S_OPEN_NS1;
            end
            S_OPEN_NS1:
            begin
                cmd.wr_en = 1'b1;
                cmd.wr_sel = sst_pkg::WR_NS1;
                state_next = S_FINISH;
            end
            S_FIND_RD:
            begin
                cmd.rd_en = 1'b1;
                state_next = S_FIND_CMP;
            end
            S_FIND_CMP:
            begin
                if (stat.hit)
                begin
                    cmd.find_hit = 1'b1;
                    state_next = S_FINISH;
                end
                else if (stat.at_floor)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.step = 1'b1;
                    state_next = S_FIND_RD;
                end
            end
            S_CLOSE_RD:
            begin
                cmd.rd_en = 1'b1;
                state_next = S_CLOSE_CMP;
            end
            S_CLOSE_CMP:
            begin
                cmd.close_cmp = 1'b1;
                // entry 0 is always a base marker, so this ends
                if (stat.is_base)
                begin
                    cmd.close_done = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.step = 1'b1;
                    state_next = S_CLOSE_RD;
                end
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.publish = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

>>> design/sst_dp.sv
`timescale 1ns / 1ps

module sst_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [sst_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sst_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [sst_pkg::ACTION_W-1:0]       in_action,
    input  logic [sst_pkg::KEY_W-1:0]          in_key,
    input  logic [sst_pkg::VALUE_W-1:0]        in_value,
    input  logic [sst_pkg::FLAGS_W-1:0]        in_flags,
    input  sst_pkg::dp_cmd_t                   cmd,
    output sst_pkg::dp_stat_t                  stat,
    output logic [sst_pkg::INDEX_W-1:0]        out_index,
    output logic                               out_found,
    output logic                               out_locked,
    output logic [sst_pkg::STATUS_W-1:0]       out_status
);

    localparam int ADDR_W = sst_pkg::ADDR_W;
    localparam int PTR_W = sst_pkg::PTR_W;

    sst_pkg::entry_t mem [sst_pkg::DEPTH];

    logic [sst_pkg::FLAGS_W-1:0] type_mask_reg;
    logic [sst_pkg::KEY_W-1:0]   inh_key_reg;
    logic [sst_pkg::FLAGS_W-1:0] ns_flags_reg;

    logic [PTR_W-1:0]  top_reg, top_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic              top_lock_reg, top_lock_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;

    sst_pkg::action_t            act_reg;
    logic [sst_pkg::KEY_W-1:0]   key_reg;
    logic [sst_pkg::VALUE_W-1:0] value_reg;
    logic [sst_pkg::FLAGS_W-1:0] flags_reg;

    logic [ADDR_W-1:0]      res_index_reg, res_index_next;
    logic                   res_found_reg, res_found_next;
    sst_pkg::status_t       res_status_reg, res_status_next;

    logic [sst_pkg::INDEX_W-1:0]  out_index_reg;
    logic                         out_found_reg;
    logic                         out_locked_reg;
    logic [sst_pkg::STATUS_W-1:0] out_status_reg;

    sst_pkg::entry_t   mem_rd_reg;
    logic              rd_init_reg;
    logic [1:0]        rd_slot_reg;
    sst_pkg::entry_t   rd_entry;
    sst_pkg::entry_t   wr_entry;
    logic [ADDR_W-1:0] top_addr;
    logic [ADDR_W-1:0] base_plus1;

    assign top_addr = top_reg[ADDR_W-1:0];
    assign base_plus1 = base_reg + ADDR_W'(1);

    // reset contents of the outermost scope, never overwritten
    always_comb
    begin
        case (rd_slot_reg)
            2'd0:
            begin
                rd_entry = '{key: '0, value: '0, flags: '0, kind: sst_pkg::KIND_BASE};
            end
            2'd1:
            begin
                rd_entry = '{key: '0, value: '0, flags: sst_pkg::RST_NS_FLAGS,
                             kind: sst_pkg::KIND_NORMAL};
            end
            2'd2:
            begin
                rd_entry = '{key: sst_pkg::RST_INH_KEY, value: '0,
                             flags: sst_pkg::RST_NS_FLAGS, kind: sst_pkg::KIND_NORMAL};
            end
            default:
            begin
                rd_entry = mem_rd_reg;
            end
        endcase
        if (!rd_init_reg)
        begin
            rd_entry = mem_rd_reg;
        end
    end

    always_comb
    begin
        case (cmd.wr_sel)
            sst_pkg::WR_BASE:
            begin
                wr_entry = '{key: '0, value: '0, flags: '0, kind: sst_pkg::KIND_BASE};
            end
            sst_pkg::WR_NS0:
            begin
                wr_entry = '{key: '0, value: '0, flags: ns_flags_reg,
                             kind: sst_pkg::KIND_NORMAL};
            end
            sst_pkg::WR_NS1:
            begin
                wr_entry = '{key: inh_key_reg, value: '0, flags: ns_flags_reg,
                             kind: sst_pkg::KIND_NORMAL};
            end
            sst_pkg::WR_LOCK:
            begin
                wr_entry = '{key: '0, value: '0, flags: '0, kind: sst_pkg::KIND_LOCK};
            end
            default:
            begin
                wr_entry = '{key: key_reg, value: value_reg, flags: flags_reg,
                             kind: sst_pkg::KIND_NORMAL};
            end
        endcase
    end

    always_comb
    begin
        stat.action = act_reg;
        stat.open_full = (top_reg > PTR_W'(sst_pkg::DEPTH - sst_pkg::OPEN_ENTRIES));
        stat.push_full = (top_reg >= PTR_W'(sst_pkg::DEPTH));
        stat.top_lock = top_lock_reg;
        stat.base_zero = (base_reg == '0);
        stat.find_empty = (top_reg <= ({1'b0, base_reg} + PTR_W'(1)));
        stat.at_floor = (ptr_reg == base_plus1);
        stat.hit = (rd_entry.kind == sst_pkg::KIND_NORMAL) && (rd_entry.key == key_reg)
                   && ((rd_entry.flags & type_mask_reg) == flags_reg);
        stat.is_base = (rd_entry.kind == sst_pkg::KIND_BASE);
    end

    always_comb
    begin
        top_next = top_reg;
        base_next = base_reg;
        top_lock_next = top_lock_reg;
        ptr_next = ptr_reg;
        res_index_next = res_index_reg;
        res_found_next = res_found_reg;
        res_status_next = res_status_reg;

        if (cmd.load)
        begin
            res_index_next = '0;
            res_found_next = 1'b0;
            res_status_next = sst_pkg::ST_OK;
        end
        if (cmd.set_status)
        begin
            res_status_next = cmd.status_code;
        end
        if (cmd.wr_en)
        begin
            top_next = top_reg + PTR_W'(1);
            case (cmd.wr_sel)
                sst_pkg::WR_BASE:
                begin
                    base_next = top_addr;
                    top_lock_next = 1'b0;
                end
                sst_pkg::WR_LOCK:
                begin
                    top_lock_next = 1'b1;
                end
                sst_pkg::WR_ADD:
                begin
                    res_index_next = top_addr;
                    top_lock_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.find_start)
        begin
            ptr_next = top_addr - ADDR_W'(1);
        end
        if (cmd.close_start)
        begin
            top_next = {1'b0, base_reg};
            ptr_next = base_reg - ADDR_W'(1);
        end
        if (cmd.step)
        begin
            ptr_next = ptr_reg - ADDR_W'(1);
        end
        if (cmd.find_hit)
        begin
            res_index_next = ptr_reg;
            res_found_next = 1'b1;
        end
        // first entry read below the closed scope becomes the new top
        if (cmd.close_cmp && (ptr_reg == top_addr - ADDR_W'(1)))
        begin
            top_lock_next = (rd_entry.kind == sst_pkg::KIND_LOCK);
        end
        if (cmd.close_done)
        begin
            base_next = ptr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_mask_reg <= sst_pkg::RST_TYPE_MASK;
            inh_key_reg <= sst_pkg::RST_INH_KEY;
            ns_flags_reg <= sst_pkg::RST_NS_FLAGS;
            top_reg <= PTR_W'(sst_pkg::INIT_ENTRIES);
            base_reg <= '0;
            top_lock_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    sst_pkg::CFG_TYPE_MASK:
                    begin
                        type_mask_reg <= cfg_data[sst_pkg::FLAGS_W-1:0];
                    end
                    sst_pkg::CFG_INH_KEY:
                    begin
                        inh_key_reg <= cfg_data[sst_pkg::KEY_W-1:0];
                    end
                    sst_pkg::CFG_NS_FLAGS:
                    begin
                        ns_flags_reg <= cfg_data[sst_pkg::FLAGS_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            top_reg <= top_next;
            base_reg <= base_next;
            top_lock_reg <= top_lock_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        res_index_reg <= res_index_next;
        res_found_reg <= res_found_next;
        res_status_reg <= res_status_next;
        if (cmd.load)
        begin
            act_reg <= sst_pkg::action_t'(in_action);
            key_reg <= in_key;
            value_reg <= in_value;
            flags_reg <= in_flags;
        end
        if (cmd.publish)
        begin
            out_index_reg <= sst_pkg::INDEX_W'(res_index_reg);
            out_found_reg <= res_found_reg;
            out_locked_reg <= top_lock_reg;
            out_status_reg <= res_status_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[top_addr] <= wr_entry;
        end
        if (cmd.rd_en)
        begin
            mem_rd_reg <= mem[ptr_reg];
            rd_init_reg <= (ptr_reg < ADDR_W'(sst_pkg::INIT_ENTRIES));
            rd_slot_reg <= ptr_reg[1:0];
        end
    end

    assign out_index = out_index_reg;
    assign out_found = out_found_reg;
    assign out_locked = out_locked_reg;
    assign out_status = out_status_reg;

endmodule

>>> design/scoped_symbol_table_core.sv
`timescale 1ns / 1ps

// channel   | dir | handshake     | payload
// ----------+-----+---------------+---------------------------------
// request   | in  | valid / ready | action, key, value, flags
// response  | out | valid / ready | index, found, locked, status
// config    | in  | cfg_wr_en     | cfg_index, cfg_data
//
// one item at a time: open writes its base marker and two namespace entries in turn
// find reads entries from the top down to the one above the scope base, stopping at a hit
// close reads entries downward until it reaches the enclosing base marker
// the scans share the single read port of the entry memory, one read per entry
// reset gives the outermost scope with its two namespace entries, no clearing pass
// a new item is taken while a result waits in the response register

module scoped_symbol_table_core (
    input  logic                               clk,
    input  logic                               rst_n,
    sst_req_if.sink                            request,
    sst_rsp_if.source                          response,
    input  logic                               cfg_wr_en,
    input  logic [sst_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sst_pkg::CFG_DATA_W-1:0]     cfg_data
);

    sst_pkg::dp_cmd_t  cmd;
    sst_pkg::dp_stat_t stat;

    sst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .rsp_valid (response.valid),
        .rsp_ready (response.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sst_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_action  (request.action),
        .in_key     (request.key),
        .in_value   (request.value),
        .in_flags   (request.flags),
        .cmd        (cmd),
        .stat       (stat),
        .out_index  (response.index),
        .out_found  (response.found),
        .out_locked (response.locked),
        .out_status (response.status)
    );

endmodule
